// File: rtl/printable_string_extractor_assert.svh
// Assertion macros used by the checker file.
`ifndef PRINTABLE_STRING_EXTRACTOR_ASSERT_SVH
`define PRINTABLE_STRING_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, gated off while dis is high.
`define PSE_ASSERT_IMP(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off while dis is high.
`define PSE_ASSERT_NXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pse_pkg.sv
package pse_pkg;

  // Sizing
  localparam int MAX_MIN_LENGTH = 32;
  localparam int OFFSET_BITS    = 32;
  localparam int COUNT_BITS     = 16;
  localparam int LEN_BITS       = 32;
  localparam int MIN_BITS       = 6;
  localparam int LIMIT_BITS     = 16;
  localparam int BYTE_BITS      = 8;
  localparam int CHAR_BITS      = 7;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int HELD_DEPTH     = MAX_MIN_LENGTH - 1;
  localparam int HELD_IDX_BITS  = $clog2(MAX_MIN_LENGTH);

  // Defaults and character class bounds
  localparam logic [MIN_BITS-1:0]   DEFAULT_MIN   = MIN_BITS'(4);
  localparam logic [LIMIT_BITS-1:0] DEFAULT_LIMIT = LIMIT_BITS'(200);
  localparam logic [BYTE_BITS-1:0]  PRINT_LO      = 8'h20;
  localparam logic [BYTE_BITS-1:0]  PRINT_HI      = 8'h7E;

  // Result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Register map
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MIN_LEN      = 1'b0,
    REG_RESULT_LIMIT = 1'b1
  } cfg_reg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic eval;       // classify byte, update run state
    logic emit_held;  // load held character into output
    logic emit_char;  // load current character into output
    logic emit_end;   // load end marker into output
    logic last;       // last result of this byte
    logic finish;     // advance position or clear buffer state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic will_flush;
    logic will_char;
    logic will_end;
    logic flush_last;
    logic plan_end;
  } sts_t;

endpackage

// File: rtl/pse_ctrl.sv
module pse_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pse_pkg::sts_t sts,
  output pse_pkg::cmd_t cmd
);
  import pse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_FLUSH,
    S_CHAR,
    S_END
  } state_t;

  state_t state;
  state_t state_next;

  // Sequencing of one byte: evaluate, then emit its results one by one
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.will_flush) begin
          state_next = S_FLUSH;
        end else if (sts.will_char) begin
          state_next = S_CHAR;
        end else if (sts.will_end) begin
          state_next = S_END;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit_held = 1'b1;
          if (sts.flush_last) begin
            state_next = S_CHAR;
          end
        end
      end
      S_CHAR: begin
        if (sts.out_free) begin
          cmd.emit_char = 1'b1;
          cmd.last      = !sts.plan_end;
          if (sts.plan_end) begin
            state_next = S_END;
          end else begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          cmd.last     = 1'b1;
          cmd.finish   = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and ready register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

// File: rtl/pse_datapath.sv
module pse_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pse_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [pse_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // input payload
  input  logic [pse_pkg::BYTE_BITS-1:0]        data_byte,
  input  logic                                 final_byte,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 item_kind,
  output logic [pse_pkg::CHAR_BITS-1:0]        char_code,
  output logic [pse_pkg::OFFSET_BITS-1:0]      string_offset,
  output logic [pse_pkg::LEN_BITS-1:0]         string_length,
  output logic [pse_pkg::COUNT_BITS-1:0]       string_number,
  output logic                                 last_of_run,
  // control
  input  pse_pkg::cmd_t                        cmd,
  output pse_pkg::sts_t                        sts
);
  import pse_pkg::*;

  // Configuration registers
  logic [MIN_BITS-1:0]      min_len;
  logic [LIMIT_BITS-1:0]    lim;
  // Captured transaction
  logic [BYTE_BITS-1:0]     cur_byte;
  logic                     cur_fin;
  // Buffer state
  logic [OFFSET_BITS-1:0]   byte_position;
  logic [OFFSET_BITS-1:0]   run_start;
  logic [LEN_BITS-1:0]      run_count;
  logic [COUNT_BITS-1:0]    strings_found;
  logic                     scan_halted;
  logic                     reporting;
  logic [CHAR_BITS-1:0]     held_chars [HELD_DEPTH];
  // Emission plan for the current byte
  logic                     plan_end;
  logic [LEN_BITS-1:0]      end_len;
  logic [HELD_IDX_BITS-1:0] flush_idx;

  logic [MIN_BITS-1:0]      m_eff;
  logic [MIN_BITS-1:0]      m_minus1;
  logic [LIMIT_BITS-1:0]    lim_eff;
  logic                     printable;
  logic [LEN_BITS-1:0]      count_inc;
  logic                     below_min;
  logic                     at_limit;
  logic                     qualify;
  logic                     reporting_after;
  logic                     held_wr;

  assign cfg_ready = 1'b1;

  // Effective minimum and limit
  always_comb begin
    if (min_len == '0) begin
      m_eff = DEFAULT_MIN;
    end else if (int'(min_len) > MAX_MIN_LENGTH) begin
      m_eff = MIN_BITS'(MAX_MIN_LENGTH);
    end else begin
      m_eff = min_len;
    end
    lim_eff = (lim == '0) ? DEFAULT_LIMIT : lim;
  end
  assign m_minus1 = m_eff - MIN_BITS'(1);

  // Byte classification against the run state
  assign printable = (cur_byte >= PRINT_LO) && (cur_byte <= PRINT_HI);
  assign count_inc = (run_count == '1) ? run_count : run_count + LEN_BITS'(1);
  assign below_min = run_count < LEN_BITS'(m_minus1);
  assign at_limit  = 64'(strings_found) >= 64'(lim_eff);
  assign qualify   = !scan_halted && printable && !reporting && !below_min && !at_limit;
  assign held_wr   = cmd.eval && !scan_halted && printable && !reporting && below_min;

  always_comb begin
    if (scan_halted) begin
      reporting_after = reporting;
    end else if (printable) begin
      reporting_after = reporting || qualify;
    end else begin
      reporting_after = 1'b0;
    end
  end

  // Status to the controller
  always_comb begin
    sts            = '0;
    sts.out_free   = !out_valid || out_ready;
    sts.will_flush = qualify && (m_minus1 != '0);
    sts.will_char  = !scan_halted && printable && (reporting || qualify);
    sts.will_end   = !scan_halted && ((!printable && reporting) ||
                                      (cur_fin && reporting_after));
    sts.flush_last = (MIN_BITS'(flush_idx) == m_minus1 - MIN_BITS'(1));
    sts.plan_end   = plan_end;
  end

  // Captured transaction (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_byte <= data_byte;
      cur_fin  <= final_byte;
    end
  end

  // Held characters of a run that has not yet qualified
  always_ff @(posedge clk) begin
    if (held_wr) begin
      held_chars[run_count[HELD_IDX_BITS-1:0]] <= cur_byte[CHAR_BITS-1:0];
    end
  end

  // Configuration and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      min_len       <= DEFAULT_MIN;
      lim           <= DEFAULT_LIMIT;
      byte_position <= '0;
      run_start     <= '0;
      run_count     <= '0;
      strings_found <= '0;
      scan_halted   <= 1'b0;
      reporting     <= 1'b0;
      plan_end      <= 1'b0;
      flush_idx     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MIN_LEN:      min_len <= cfg_data[MIN_BITS-1:0];
          REG_RESULT_LIMIT: lim     <= cfg_data[LIMIT_BITS-1:0];
          default:          ;
        endcase
      end

      if (cmd.eval) begin
        plan_end  <= sts.will_end;
        flush_idx <= '0;
        if (!scan_halted) begin
          if (printable) begin
            if (run_count == '0) begin
              run_start <= byte_position;
            end
            run_count <= count_inc;
            if (!reporting && !below_min && at_limit) begin
              scan_halted <= 1'b1;
              run_count   <= '0;
            end else if (qualify) begin
              strings_found <= strings_found + COUNT_BITS'(1);
              reporting     <= 1'b1;
            end
          end else begin
            run_count <= '0;
            reporting <= 1'b0;
          end
        end
      end

      if (cmd.emit_held) begin
        flush_idx <= flush_idx + HELD_IDX_BITS'(1);
      end

      // End of byte: the final byte returns the buffer state to reset
      if (cmd.finish) begin
        if (cur_fin) begin
          byte_position <= '0;
          run_start     <= '0;
          run_count     <= '0;
          strings_found <= '0;
          scan_halted   <= 1'b0;
          reporting     <= 1'b0;
        end else begin
          byte_position <= byte_position + OFFSET_BITS'(1);
        end
      end
    end
  end

  // Saturated run length for an end marker (payload)
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      end_len <= printable ? count_inc : run_count;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_held || cmd.emit_char || cmd.emit_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (cmd.emit_held || cmd.emit_char || cmd.emit_end) begin
      string_offset <= run_start;
      string_number <= strings_found - COUNT_BITS'(1);
      last_of_run   <= cmd.last;
      if (cmd.emit_end) begin
        item_kind     <= KIND_END;
        char_code     <= '0;
        string_length <= end_len;
      end else begin
        item_kind     <= KIND_CHAR;
        string_length <= '0;
        if (cmd.emit_held) begin
          char_code <= held_chars[flush_idx];
        end else begin
          char_code <= cur_byte[CHAR_BITS-1:0];
        end
      end
    end
  end

endmodule

// File: rtl/printable_string_extractor.sv
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_ready   data_byte, final_byte
// out       source     out_valid / out_ready item_kind, char_code, string_offset,
//                                            string_length, string_number, last_of_run
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// A byte is taken from the input in the idle state, classified in the controller's
// evaluate state, and then each result it produces is loaded into the output
// register; a qualifying byte first flushes the held characters of its run.
// Reset is synchronous; in_ready is registered and rises in the cycle after reset.
// An output stall holds the sequencer in its emit state; the next byte is taken
// while the last result of the previous one is still waiting.
module printable_string_extractor (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pse_pkg::BYTE_BITS-1:0]      data_byte,
  input  logic                               final_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               item_kind,
  output logic [pse_pkg::CHAR_BITS-1:0]      char_code,
  output logic [pse_pkg::OFFSET_BITS-1:0]    string_offset,
  output logic [pse_pkg::LEN_BITS-1:0]       string_length,
  output logic [pse_pkg::COUNT_BITS-1:0]     string_number,
  output logic                               last_of_run,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pse_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pse_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import pse_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Run state, held characters and output register
  pse_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .data_byte     (data_byte),
    .final_byte    (final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .item_kind     (item_kind),
    .char_code     (char_code),
    .string_offset (string_offset),
    .string_length (string_length),
    .string_number (string_number),
    .last_of_run   (last_of_run),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// File: rtl/pse_checker.sv
`include "printable_string_extractor_assert.svh"

module pse_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [pse_pkg::BYTE_BITS-1:0]      data_byte,
  input logic                               final_byte,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               item_kind,
  input logic [pse_pkg::CHAR_BITS-1:0]      char_code,
  input logic [pse_pkg::OFFSET_BITS-1:0]    string_offset,
  input logic [pse_pkg::LEN_BITS-1:0]       string_length,
  input logic [pse_pkg::COUNT_BITS-1:0]     string_number,
  input logic                               last_of_run
);
  import pse_pkg::*;

  // No result straight out of reset
  `PSE_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !out_valid, "result valid after reset")

  // A byte is evaluated before the next one is taken
  `PSE_ASSERT_NXT(a_one_byte, clk, rst, in_valid && in_ready, !in_ready,
                  "input taken in back-to-back cycles")

  // A waiting input transaction keeps its payload
  `PSE_ASSERT_NXT(a_in_hold, clk, rst, in_valid && !in_ready,
                  in_valid && $stable(data_byte) && $stable(final_byte),
                  "waiting input changed")

  // More results of the same byte follow without a gap
  `PSE_ASSERT_NXT(a_run_cont, clk, rst, out_valid && out_ready && !last_of_run, out_valid,
                  "gap inside the results of one byte")

  // A held result keeps its payload
  `PSE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
                  out_valid && $stable(item_kind) && $stable(char_code) &&
                  $stable(string_offset) && $stable(string_number) &&
                  $stable(string_length) && $stable(last_of_run),
                  "stalled result changed")

endmodule

bind printable_string_extractor pse_checker u_pse_checker (.*);
